FILE: src/led_color_effect_generator_macros.svh
// ----------------------------------------------------------------------------
// LED color effect generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LED_COLOR_EFFECT_GENERATOR_MACROS_SVH
`define LED_COLOR_EFFECT_GENERATOR_MACROS_SVH

// expr must never hold
`define LCEG_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// cons holds in the same cycle as ante
`define LCEG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define LCEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lceg_pkg.sv
// ----------------------------------------------------------------------------
// LED color effect generator package
// Sizes, constants, codes and state type shared by the block's files.
// ----------------------------------------------------------------------------
package lceg_pkg;

  localparam int PALETTE_DEPTH = 512;
  localparam int VALUE_TOP     = 100;
  localparam int VALUE_BOTTOM  = 0;
  localparam int SAT_TOP       = 100;

  localparam int OP_W    = 2;
  localparam int MODE_W  = 3;
  localparam int PCNT_W  = 10;
  localparam int HUE_W   = 9;
  localparam int PIDX_W  = 9;
  localparam int VAL_W   = 8;
  localparam int DLY_W   = 15;
  localparam int RAND_W  = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int ADDR_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;
  localparam int DIV_W  = (CNT_W > VAL_W) ? CNT_W : VAL_W;

  // remainder unit retires two dividend bits per cycle
  localparam int DIV_STEPS = RAND_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_PAL_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_START     = 2'd2;

  localparam logic [MODE_W-1:0] MODE_JUMP      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FADE      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RAND_JUMP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RAND_FADE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RAND_HV   = 3'd4;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_RISE  = 2'd2;
  localparam logic [1:0] REG_FALL  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CALC
  } state_t;

endpackage

FILE: src/lceg_cmd_if.sv
// ----------------------------------------------------------------------------
// LED color effect generator request channel
// Valid/ready channel carrying tick, palette write and start requests.
// ----------------------------------------------------------------------------
interface lceg_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [lceg_pkg::OP_W-1:0]    opcode;
  logic [lceg_pkg::PIDX_W-1:0]  palette_index;
  logic [lceg_pkg::HUE_W-1:0]   palette_hue;
  logic [lceg_pkg::RAND_W-1:0]  random_first;
  logic [lceg_pkg::RAND_W-1:0]  random_second;

  modport source (
    output valid, opcode, palette_index, palette_hue, random_first, random_second,
    input  ready
  );
  modport sink (
    input  valid, opcode, palette_index, palette_hue, random_first, random_second,
    output ready
  );
endinterface

FILE: src/lceg_result_if.sv
// ----------------------------------------------------------------------------
// LED color effect generator result channel
// Valid/ready channel carrying one HSV color and its delay per tick.
// ----------------------------------------------------------------------------
interface lceg_result_if;
  logic                        valid;
  logic                        ready;
  logic [lceg_pkg::HUE_W-1:0]  hue;
  logic [lceg_pkg::VAL_W-1:0]  saturation;
  logic [lceg_pkg::VAL_W-1:0]  brightness;
  logic [lceg_pkg::DLY_W-1:0]  delay_ms;

  modport source (
    output valid, hue, saturation, brightness, delay_ms,
    input  ready
  );
  modport sink (
    input  valid, hue, saturation, brightness, delay_ms,
    output ready
  );
endinterface

FILE: src/lceg_ram.sv
// ----------------------------------------------------------------------------
// LED color effect generator RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lceg_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/led_color_effect_generator.sv
// ----------------------------------------------------------------------------
// LED color effect generator
// Palette based HSV effect sequencer with an APB configuration port.
// ----------------------------------------------------------------------------
// Palette write, start: accepted with no result.
// Tick, modes 0, 1, 5-7: palette read (ST_READ), then ST_CALC registers the result once the output is free.
// Tick, modes 2, 3: a remainder pass (ST_DIV) comes first; mode 4: two passes. The
//   remainder unit takes 2 dividend bits per cycle of each 32-bit word.
// One tick in flight; next request taken while the result waits.
// Reset clears control and config; palette is undefined until written.

`include "led_color_effect_generator_macros.svh"

module led_color_effect_generator (
  input  logic                            clk,
  input  logic                            rst,
  lceg_cmd_if.sink                        cmd,
  lceg_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lceg_pkg::PADDR_W-1:0]    paddr,
  input  logic [lceg_pkg::PDATA_W-1:0]    pwdata,
  output logic [lceg_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int ADDR_W = lceg_pkg::ADDR_W;
  localparam int CNT_W  = lceg_pkg::CNT_W;
  localparam int CMP_W  = lceg_pkg::CMP_W;
  localparam int DIV_W  = lceg_pkg::DIV_W;
  localparam int HUE_W  = lceg_pkg::HUE_W;
  localparam int VAL_W  = lceg_pkg::VAL_W;
  localparam int DLY_W  = lceg_pkg::DLY_W;
  localparam int MODE_W = lceg_pkg::MODE_W;
  localparam int PCNT_W = lceg_pkg::PCNT_W;
  localparam int RAND_W = lceg_pkg::RAND_W;
  localparam int STEP_W = lceg_pkg::STEP_W;
  localparam int PDATA_W = lceg_pkg::PDATA_W;

  // configuration
  logic [MODE_W-1:0] effect_mode;
  logic [PCNT_W-1:0] palette_count;
  logic [DLY_W-1:0]  rise_delay_ms;
  logic [DLY_W-1:0]  fall_delay_ms;
  logic              cfg_we;

  // effect state
  logic [ADDR_W-1:0] position;
  logic [HUE_W-1:0]  cur_hue;
  logic [VAL_W-1:0]  cur_value;
  logic              rising;

  // sequencer and remainder unit
  lceg_pkg::state_t  state;
  lceg_pkg::state_t  state_next;
  logic              div_pass;
  logic [STEP_W-1:0] div_cnt;
  logic [RAND_W-1:0] div_dvd;
  logic [DIV_W-1:0]  div_rem;
  logic [RAND_W-1:0] tick_r2;
  logic [ADDR_W-1:0] mod_cnt;
  logic [VAL_W-1:0]  mod_val;
  logic [DIV_W-1:0]  div_d;
  logic [DIV_W:0]    t1;
  logic [DIV_W:0]    t2;
  logic [DIV_W-1:0]  rs1;
  logic [DIV_W-1:0]  rs2;
  logic              div_last;
  logic              need_div;

  // result register
  logic              res_valid;
  logic [HUE_W-1:0]  res_hue;
  logic [VAL_W-1:0]  res_val;
  logic [DLY_W-1:0]  res_dly;
  logic              out_free;

  // handshakes and palette memory
  logic              cmd_fire;
  logic              calc_fire;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [HUE_W-1:0]  ram_rdata;

  // tick update
  logic [CMP_W-1:0]  pc_ext;
  logic [CNT_W-1:0]  used_cnt;
  logic [CNT_W-1:0]  pos_inc;
  logic [ADDR_W-1:0] pos_adv;
  logic [VAL_W:0]    fv;
  logic              fr;
  logic [HUE_W-1:0]  hue_n;
  logic [VAL_W-1:0]  val_n;
  logic              ris_n;
  logic              adv;
  logic [HUE_W-1:0]  hue_keep;

  // ---------------------------------------------------------------- config
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= lceg_pkg::MODE_JUMP;
      palette_count <= PCNT_W'(3);
      rise_delay_ms <= '0;
      fall_delay_ms <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        lceg_pkg::REG_MODE:  effect_mode   <= pwdata[MODE_W-1:0];
        lceg_pkg::REG_COUNT: palette_count <= pwdata[PCNT_W-1:0];
        lceg_pkg::REG_RISE:  rise_delay_ms <= pwdata[DLY_W-1:0];
        lceg_pkg::REG_FALL:  fall_delay_ms <= pwdata[DLY_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lceg_pkg::REG_MODE:  prdata = PDATA_W'(effect_mode);
      lceg_pkg::REG_COUNT: prdata = PDATA_W'(palette_count);
      lceg_pkg::REG_RISE:  prdata = PDATA_W'(rise_delay_ms);
      lceg_pkg::REG_FALL:  prdata = PDATA_W'(fall_delay_ms);
    endcase
  end

  // ------------------------------------------------------------ palette RAM
  assign ram_we    = cmd_fire && (cmd.opcode == lceg_pkg::OP_PAL_WRITE) &&
                     (int'(cmd.palette_index) < lceg_pkg::PALETTE_DEPTH);
  assign ram_waddr = ADDR_W'(cmd.palette_index);
  assign ram_raddr = need_div ? mod_cnt : position;

  lceg_ram #(
    .WIDTH (HUE_W),
    .DEPTH (lceg_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.palette_hue),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------- count clamp
  always_comb begin
    pc_ext = CMP_W'(palette_count);
    if (palette_count == '0) begin
      used_cnt = CNT_W'(1);
    end else if (pc_ext > CMP_W'(lceg_pkg::PALETTE_DEPTH)) begin
      used_cnt = CNT_W'(lceg_pkg::PALETTE_DEPTH);
    end else begin
      used_cnt = CNT_W'(palette_count);
    end
  end

  assign pos_inc = CNT_W'(position) + CNT_W'(1);
  assign pos_adv = (pos_inc >= used_cnt) ? '0 : ADDR_W'(pos_inc);

  // -------------------------------------------------------- remainder unit
  assign need_div = (effect_mode == lceg_pkg::MODE_RAND_JUMP) ||
                    (effect_mode == lceg_pkg::MODE_RAND_FADE) ||
                    (effect_mode == lceg_pkg::MODE_RAND_HV);
  assign div_d    = div_pass ? DIV_W'(lceg_pkg::VALUE_TOP) : DIV_W'(used_cnt);
  assign t1       = {div_rem, div_dvd[RAND_W-1]};
  assign rs1      = (t1 >= {1'b0, div_d}) ? DIV_W'(t1 - {1'b0, div_d}) : DIV_W'(t1);
  assign t2       = {rs1, div_dvd[RAND_W-2]};
  assign rs2      = (t2 >= {1'b0, div_d}) ? DIV_W'(t2 - {1'b0, div_d}) : DIV_W'(t2);
  assign div_last = (div_cnt == STEP_W'(lceg_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      div_dvd  <= cmd.random_first;
      tick_r2  <= cmd.random_second;
      div_rem  <= '0;
      div_cnt  <= '0;
      div_pass <= 1'b0;
    end else if (state == lceg_pkg::ST_DIV) begin
      div_dvd <= {div_dvd[RAND_W-3:0], 2'b00};
      div_rem <= rs2;
      div_cnt <= div_cnt + STEP_W'(1);
      if (div_last) begin
        if (!div_pass) begin
          mod_cnt <= ADDR_W'(rs2);
        end else begin
          mod_val <= VAL_W'(rs2);
        end
        if (!div_pass && (effect_mode == lceg_pkg::MODE_RAND_HV)) begin
          div_pass <= 1'b1;
          div_dvd  <= tick_r2;
          div_rem  <= '0;
          div_cnt  <= '0;
        end
      end
    end
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      lceg_pkg::ST_IDLE: begin
        if (cmd_fire && (cmd.opcode == lceg_pkg::OP_TICK)) begin
          state_next = need_div ? lceg_pkg::ST_DIV : lceg_pkg::ST_READ;
        end
      end
      lceg_pkg::ST_DIV: begin
        if (div_last && (div_pass || (effect_mode != lceg_pkg::MODE_RAND_HV))) begin
          state_next = lceg_pkg::ST_READ;
        end
      end
      lceg_pkg::ST_READ: state_next = lceg_pkg::ST_CALC;
      lceg_pkg::ST_CALC: begin
        if (out_free) begin
          state_next = lceg_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd.ready = (state == lceg_pkg::ST_IDLE);
    ram_re    = (state == lceg_pkg::ST_READ);
    out_free  = !res_valid || result.ready;
    calc_fire = (state == lceg_pkg::ST_CALC) && out_free;
  end

  assign cmd_fire = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lceg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------------ tick update
  always_comb begin
    fv = {1'b0, cur_value};
    fr = rising;
    if (fv <= (VAL_W+1)'(lceg_pkg::VALUE_BOTTOM)) fr = 1'b1;
    if (fr && (fv < (VAL_W+1)'(lceg_pkg::VALUE_TOP))) fv = fv + (VAL_W+1)'(1);
    if (fv >= (VAL_W+1)'(lceg_pkg::VALUE_TOP)) fr = 1'b0;
    if (!fr && (fv > (VAL_W+1)'(lceg_pkg::VALUE_BOTTOM))) fv = fv - (VAL_W+1)'(1);

    hue_n = cur_hue;
    val_n = cur_value;
    ris_n = rising;
    case (effect_mode)
      lceg_pkg::MODE_JUMP, lceg_pkg::MODE_RAND_JUMP: begin
        hue_n = ram_rdata;
      end
      lceg_pkg::MODE_FADE: begin
        hue_n = ram_rdata;
        val_n = VAL_W'(fv);
        ris_n = fr;
      end
      lceg_pkg::MODE_RAND_FADE: begin
        val_n = VAL_W'(fv);
        ris_n = fr;
      end
      lceg_pkg::MODE_RAND_HV: begin
        hue_n = ram_rdata;
        val_n = mod_val;
      end
      default: ;
    endcase

    adv      = 1'b0;
    hue_keep = hue_n;
    case (effect_mode)
      lceg_pkg::MODE_JUMP, lceg_pkg::MODE_RAND_JUMP: adv = 1'b1;
      lceg_pkg::MODE_FADE, lceg_pkg::MODE_RAND_FADE: begin
        if (val_n == VAL_W'(lceg_pkg::VALUE_BOTTOM)) begin
          adv   = 1'b1;
          ris_n = 1'b1;
          if (effect_mode == lceg_pkg::MODE_RAND_FADE) hue_keep = ram_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      cur_hue   <= '0;
      cur_value <= VAL_W'(lceg_pkg::VALUE_TOP);
      rising    <= 1'b1;
    end else if (cmd_fire && (cmd.opcode == lceg_pkg::OP_START)) begin
      position  <= '0;
      cur_hue   <= '0;
      cur_value <= VAL_W'(lceg_pkg::VALUE_TOP);
      rising    <= 1'b0;
    end else if (calc_fire) begin
      cur_hue   <= hue_keep;
      cur_value <= val_n;
      rising    <= ris_n;
      if (adv) position <= pos_adv;
    end
  end

  // --------------------------------------------------------- result output
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (calc_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_fire) begin
      res_hue <= hue_n;
      res_val <= val_n;
      res_dly <= ris_n ? rise_delay_ms : fall_delay_ms;
    end
  end

  assign result.valid      = res_valid;
  assign result.hue        = res_hue;
  assign result.saturation = VAL_W'(lceg_pkg::SAT_TOP);
  assign result.brightness = res_val;
  assign result.delay_ms   = res_dly;

  // ------------------------------------------------------------ assertions
  `LCEG_ASSERT_NEVER(a_value_top, cur_value > VAL_W'(lceg_pkg::VALUE_TOP), "value above top")
  `LCEG_ASSERT_NEXT(a_pos_wrap, calc_fire && adv, CNT_W'(position) < $past(used_cnt), "position not wrapped")
  `LCEG_ASSERT_IMPLIES(a_result_src, $rose(result.valid), $past(state == lceg_pkg::ST_CALC), "result without tick")

endmodule

FILE: verif/led_color_effect_generator_tb.sv
// ----------------------------------------------------------------------------
// LED color effect generator testbench
// Drives tick, palette write and start requests with random idling. Checks
// every HSV result against a cycle-free model of the effect sequencer. Config
// changes go over APB between phases, once the block has drained.
// ----------------------------------------------------------------------------
module led_color_effect_generator_tb;
  import lceg_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd6;
  localparam logic [MODE_W-1:0] MODE_TOP    = 3'd7;
  localparam logic [DLY_W-1:0]  DLY_MAX     = '1;

  localparam int IDLE_PCT      = 35;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 145;
  localparam int NUM_PHASES    = 12;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PIDX_W-1:0] pidx;
    logic [HUE_W-1:0]  phue;
    logic [RAND_W-1:0] r1;
    logic [RAND_W-1:0] r2;
  } color_req_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] bri;
    logic [DLY_W-1:0] dly;
  } hsv_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lceg_cmd_if    cmd_ch();
  lceg_result_if res_ch();

  led_color_effect_generator dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow config and effect state
  logic [MODE_W-1:0] cfg_mode;
  logic [PCNT_W-1:0] cfg_count;
  logic [DLY_W-1:0]  cfg_rise;
  logic [DLY_W-1:0]  cfg_fall;
  logic [HUE_W-1:0]  pal_mem [PALETTE_DEPTH];
  int                pos;
  logic [HUE_W-1:0]  cur_hue;
  int                cur_val;
  bit                rising;

  bit         pal_written [PALETTE_DEPTH];
  color_req_t req_q [$];
  hsv_t       color_q [$];
  color_req_t offered;
  int         reqs_queued;
  int         reqs_taken;

  bit send_calm;
  bit recv_calm;
  int hold_asks;
  int hold_taken;
  int hold_left;

  int mismatch_cnt;
  int n_checked;
  int n_writes;
  int n_starts;
  int n_ignored;
  int ticks_by_mode [8];
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic int clamp_count(input int c);
    if (c == 0) return 1;
    if (c > PALETTE_DEPTH) return PALETTE_DEPTH;
    return c;
  endfunction

  function automatic logic [HUE_W-1:0] random_entry(input logic [RAND_W-1:0] r);
    return pal_mem[r % RAND_W'(clamp_count(cfg_count))];
  endfunction

  task automatic advance_position();
    pos = (pos + 1 >= clamp_count(cfg_count)) ? 0 : pos + 1;
  endtask

  task automatic fade_value();
    if (cur_val <= VALUE_BOTTOM) rising = 1'b1;
    if (rising && cur_val < VALUE_TOP) cur_val++;
    if (cur_val >= VALUE_TOP) rising = 1'b0;
    if (!rising && cur_val > VALUE_BOTTOM) cur_val--;
  endtask

  task automatic predict_request(input color_req_t rq);
    hsv_t want;
    reqs_taken++;
    case (rq.opcode)
      OP_PAL_WRITE: begin
        pal_mem[rq.pidx] = rq.phue;
        n_writes++;
      end
      OP_START: begin
        cur_val = VALUE_TOP;
        cur_hue = '0;
        pos     = 0;
        rising  = 1'b0;
        n_starts++;
      end
      OP_TICK: begin
        ticks_by_mode[cfg_mode]++;
        case (cfg_mode)
          MODE_JUMP:      cur_hue = pal_mem[pos];
          MODE_FADE: begin
            fade_value();
            cur_hue = pal_mem[pos];
          end
          MODE_RAND_JUMP: cur_hue = random_entry(rq.r1);
          MODE_RAND_FADE: fade_value();
          MODE_RAND_HV: begin
            cur_hue = random_entry(rq.r1);
            cur_val = int'(rq.r2 % RAND_W'(VALUE_TOP));
          end
          default: ;
        endcase
        want.hue = cur_hue;
        want.sat = VAL_W'(SAT_TOP);
        want.bri = VAL_W'(cur_val);
        if (cfg_mode == MODE_JUMP || cfg_mode == MODE_RAND_JUMP) begin
          advance_position();
        end else if ((cfg_mode == MODE_FADE || cfg_mode == MODE_RAND_FADE) &&
                     cur_val == VALUE_BOTTOM) begin
          rising = 1'b1;
          advance_position();
          // new hue only shows from the next tick
          if (cfg_mode == MODE_RAND_FADE) cur_hue = random_entry(rq.r1);
        end
        want.dly = rising ? cfg_rise : cfg_fall;
        color_q.push_back(want);
      end
      default: n_ignored++;
    endcase
  endtask

  // request sender
  always @(posedge clk) begin : sender
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) predict_request(offered);
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (req_q.size() != 0 && (send_calm || $urandom_range(99) >= IDLE_PCT)) begin
          offered = req_q.pop_front();
          cmd_ch.valid         <= 1'b1;
          cmd_ch.opcode        <= offered.opcode;
          cmd_ch.palette_index <= offered.pidx;
          cmd_ch.palette_hue   <= offered.phue;
          cmd_ch.random_first  <= offered.r1;
          cmd_ch.random_second <= offered.r2;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result checker and ready
  always @(posedge clk) begin : receiver
    hsv_t got;
    hsv_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.hue, res_ch.saturation, res_ch.brightness, res_ch.delay_ms};
        if (color_q.size() == 0) begin
          report_mismatch($sformatf("result hue %0d value %0d with no tick pending",
                                    got.hue, got.bri));
        end else begin
          want = color_q.pop_front();
          n_checked++;
          if (got.hue !== want.hue)
            report_mismatch($sformatf("hue %0d, expected %0d", got.hue, want.hue));
          if (got.sat !== want.sat)
            report_mismatch($sformatf("saturation %0d, expected %0d", got.sat, want.sat));
          if (got.bri !== want.bri)
            report_mismatch($sformatf("brightness %0d, expected %0d", got.bri, want.bri));
          if (got.dly !== want.dly)
            report_mismatch($sformatf("delay %0d, expected %0d", got.dly, want.dly));
        end
      end
      if (hold_taken != hold_asks) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= recv_calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout, no progress", $time);
      $display("led_color_effect_generator_tb failed");
      $finish;
    end
  end

  function automatic logic [RAND_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return RAND_W'($urandom_range(0, 1023));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HUE_W-1:0] rand_hue();
    if ($urandom_range(7) == 0) return HUE_W'($urandom_range(360, 511));
    return HUE_W'($urandom_range(0, 359));
  endfunction

  function automatic logic [DLY_W-1:0] rand_delay();
    case ($urandom_range(5))
      0:       return '0;
      1:       return DLY_MAX;
      default: return DLY_W'($urandom_range(0, DLY_MAX));
    endcase
  endfunction

  function automatic int rand_count();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(PALETTE_DEPTH + 1, 1023);
      2:       return $urandom_range(9, PALETTE_DEPTH);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic push_req(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] idx,
                          input logic [HUE_W-1:0] h, input logic [RAND_W-1:0] r1,
                          input logic [RAND_W-1:0] r2);
    if (op == OP_PAL_WRITE) pal_written[idx] = 1'b1;
    req_q.push_back('{op, idx, h, r1, r2});
    reqs_queued++;
  endtask

  task automatic push_tick(input logic [RAND_W-1:0] r1, input logic [RAND_W-1:0] r2);
    push_req(OP_TICK, PIDX_W'($urandom), rand_hue(), r1, r2);
  endtask

  task automatic push_random_item(input bit fading);
    int roll;
    logic [OP_W-1:0] op;
    roll = $urandom_range(99);
    // fades need long runs without a start to reach the bottom and turn
    if (roll < (fading ? 2 : 8)) op = OP_START;
    else if (roll < (fading ? 10 : 20)) op = OP_PAL_WRITE;
    else if (roll < (fading ? 13 : 25)) op = OP_UNUSED;
    else op = OP_TICK;
    push_req(op, PIDX_W'($urandom), rand_hue(), rand_word(), rand_word());
  endtask

  task automatic wait_idle();
    while (reqs_taken != reqs_queued || color_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:  cfg_mode  = val[MODE_W-1:0];
      REG_COUNT: cfg_count = val[PCNT_W-1:0];
      REG_RISE:  cfg_rise  = val[DLY_W-1:0];
      REG_FALL:  cfg_fall  = val[DLY_W-1:0];
      default: ;
    endcase
  endtask

  // drain, reprogram, then make sure every entry in use has been written
  task automatic set_effect(input logic [MODE_W-1:0] m, input int cnt,
                            input logic [DLY_W-1:0] rise, input logic [DLY_W-1:0] fall);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MODE, PDATA_W'(m));
    write_reg(REG_COUNT, PDATA_W'(cnt));
    write_reg(REG_RISE, PDATA_W'(rise));
    write_reg(REG_FALL, PDATA_W'(fall));
    for (int i = 0; i < clamp_count(cnt); i++)
      if (!pal_written[i]) push_req(OP_PAL_WRITE, PIDX_W'(i), rand_hue(), $urandom, $urandom);
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0] phase_modes [NUM_PHASES];
    int phase_counts [NUM_PHASES];
    logic [MODE_W-1:0] m;
    bit fading;

    phase_modes  = '{MODE_FADE, MODE_RAND_FADE, MODE_JUMP, MODE_RAND_HV, MODE_FADE,
                     MODE_RAND_JUMP, MODE_UNUSED, MODE_RAND_FADE, MODE_JUMP, MODE_FADE,
                     MODE_RAND_HV, MODE_RAND_JUMP};
    // negative: pick at random
    phase_counts = '{5, 3, 1023, PALETTE_DEPTH, 2, 0, 7, -1, -1, -1, -1, -1};

    cmd_ch.valid         = 1'b0;
    cmd_ch.opcode        = OP_TICK;
    cmd_ch.palette_index = '0;
    cmd_ch.palette_hue   = '0;
    cmd_ch.random_first  = '0;
    cmd_ch.random_second = '0;
    res_ch.ready         = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst     = 1'b1;

    cfg_mode  = MODE_JUMP;
    cfg_count = PCNT_W'(3);
    cfg_rise  = '0;
    cfg_fall  = '0;
    pos       = 0;
    cur_hue   = '0;
    cur_val   = VALUE_TOP;
    rising    = 1'b1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset config: jump through three entries, wrap, start rewinds
    push_req(OP_PAL_WRITE, '0, '0, '0, '0);
    push_req(OP_PAL_WRITE, PIDX_W'(1), HUE_W'(359), '1, '1);
    push_req(OP_PAL_WRITE, PIDX_W'(2), '1, $urandom, $urandom);
    push_req(OP_PAL_WRITE, '1, rand_hue(), $urandom, $urandom);
    repeat (4) push_tick(rand_word(), rand_word());
    push_req(OP_UNUSED, '1, '1, '1, '1);
    push_req(OP_START, '0, '0, '0, '0);
    repeat (2) push_tick(rand_word(), rand_word());

    // count lowered below the current position
    set_effect(MODE_JUMP, 1, DLY_MAX, '0);
    repeat (2) push_tick(rand_word(), rand_word());

    // count of zero acts as one
    set_effect(MODE_RAND_HV, 0, '0, DLY_MAX);
    push_tick('1, '1);
    push_tick('0, '0);
    push_tick($urandom, $urandom);

    set_effect(MODE_TOP, 3, DLY_W'(1), DLY_W'(2));
    push_tick($urandom, $urandom);
    push_req(OP_START, '0, '0, '0, '0);
    push_tick($urandom, $urandom);

    set_effect(MODE_FADE, 2, rand_delay(), rand_delay());
    repeat (2) push_tick($urandom, $urandom);

    set_effect(MODE_RAND_JUMP, 3, rand_delay(), rand_delay());
    push_tick('1, $urandom);

    set_effect(MODE_RAND_FADE, 3, rand_delay(), rand_delay());
    repeat (2) push_tick($urandom, $urandom);

    for (int p = 0; p < NUM_PHASES; p++) begin
      m = phase_modes[p];
      set_effect(m, (phase_counts[p] < 0) ? rand_count() : phase_counts[p],
                 rand_delay(), rand_delay());
      fading    = (m == MODE_FADE || m == MODE_RAND_FADE);
      send_calm = (p == 0 || p == 4);
      recv_calm = (p == 4);
      // long result back-pressure while requests keep coming
      if (p == 0) hold_asks++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) wait_idle();
        push_random_item(fading);
      end
    end

    wait_idle();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (color_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", color_q.size()));

    $display("run: %0d results checked, %0d palette writes, %0d starts, %0d ignored ops",
             n_checked, n_writes, n_starts, n_ignored);
    $display("ticks by mode: jump %0d fade %0d rjump %0d rfade %0d rhv %0d unused %0d",
             ticks_by_mode[MODE_JUMP], ticks_by_mode[MODE_FADE],
             ticks_by_mode[MODE_RAND_JUMP], ticks_by_mode[MODE_RAND_FADE],
             ticks_by_mode[MODE_RAND_HV],
             ticks_by_mode[5] + ticks_by_mode[MODE_UNUSED] + ticks_by_mode[MODE_TOP]);
    if (mismatch_cnt == 0) begin
      $display("led_color_effect_generator_tb passed");
    end else begin
      $display("led_color_effect_generator_tb failed");
    end
    $finish;
  end

endmodule
